FILE: src/imu_rfe_pkg.sv
// Shared types, constants and helpers for the IMU report field extractor.
// No dependencies; used by imu_rfe_walk and imu_report_field_extractor.
package imu_rfe_pkg;

  localparam int unsigned NUM_SECTIONS = 12;
  localparam logic [7:0]  REPORT_TAG   = 8'h11;
  localparam logic [2:0]  WALK_POS     = 3'd7;
  localparam logic [3:0]  NO_SECTION   = 4'd12;

  // Section numbers that carry kept quantities.
  localparam logic [3:0] SEC_ACCEL = 4'd1;
  localparam logic [3:0] SEC_GYRO  = 4'd2;
  localparam logic [3:0] SEC_MAG   = 4'd3;
  localparam logic [3:0] SEC_BARO  = 4'd4;
  localparam logic [3:0] SEC_EULER = 4'd6;

  // Quantity codes of the first component of each kept group, and the last code.
  localparam logic [3:0] Q_ACCEL_X  = 4'd0;
  localparam logic [3:0] Q_GYRO_X   = 4'd3;
  localparam logic [3:0] Q_MAG_X    = 4'd6;
  localparam logic [3:0] Q_PRESSURE = 4'd9;
  localparam logic [3:0] Q_HEIGHT   = 4'd10;
  localparam logic [3:0] Q_ROLL     = 4'd11;
  localparam logic [3:0] Q_LAST     = 4'd13;

  // One result from the parser.
  typedef struct packed {
    logic               valid;
    logic [3:0]         quantity;
    logic signed [23:0] raw_value;
  } result_t;

  // Byte length of each section, minus one.
  function automatic logic [2:0] section_last(input logic [3:0] sec);
    logic [2:0] len_m1;
    unique case (sec)
      4'd4, 4'd5: len_m1 = 3'd7;
      4'd8:       len_m1 = 3'd4;
      4'd10:      len_m1 = 3'd1;
      4'd11:      len_m1 = 3'd0;
      default:    len_m1 = 3'd5;
    endcase
    return len_m1;
  endfunction

  // First present section at or above 'from'; NO_SECTION if none.
  function automatic logic [3:0] find_section(input logic [11:0] mask,
                                              input logic [3:0]  from);
    logic [3:0] found;
    found = NO_SECTION;
    for (int i = NUM_SECTIONS - 1; i >= 0; i--) begin
      if (mask[i] && (4'(i) >= from)) begin
        found = 4'(i);
      end
    end
    return found;
  endfunction

endpackage

FILE: src/imu_rfe_walk.sv
// Header and section walker of the IMU report field extractor.
// Depends on imu_rfe_pkg for constants, section layouts and result_t.
module imu_rfe_walk (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   body_start,
  output imu_rfe_pkg::result_t   res
);
  import imu_rfe_pkg::*;

  logic [2:0]  byte_position, byte_position_next;
  logic        body_active, body_active_next;
  logic [11:0] section_mask, section_mask_next;
  logic [3:0]  current_section, current_section_next;
  logic [2:0]  section_byte, section_byte_next;
  logic [23:0] value_accumulator, value_accumulator_next;

  logic [3:0]  next_sec;
  logic [3:0]  base;
  logic        kept;
  logic [2:0]  header_pos_inc;

  // Next state and result for the byte on the input.
  always_comb begin
    byte_position_next     = byte_position;
    body_active_next       = body_active;
    section_mask_next      = section_mask;
    current_section_next   = current_section;
    section_byte_next      = section_byte;
    value_accumulator_next = value_accumulator;
    res                    = '0;
    next_sec               = NO_SECTION;
    base                   = Q_ACCEL_X;
    kept                   = 1'b0;
    header_pos_inc         = byte_position + 3'd1;

    if (body_start) begin
      // A start byte drops whatever was in progress and opens a new body if it is the tag.
      body_active_next       = (data_byte == REPORT_TAG);
      byte_position_next     = 3'd1;
      section_mask_next      = '0;
      current_section_next   = '0;
      section_byte_next      = '0;
      value_accumulator_next = '0;
    end else if (body_active) begin
      if (byte_position != WALK_POS) begin
        // Header bytes: mask low byte, mask high nibble, then four skipped.
        if (byte_position == 3'd1) begin
          section_mask_next = {section_mask[11:8], data_byte};
        end else if (byte_position == 3'd2) begin
          section_mask_next = {data_byte[3:0], section_mask[7:0]};
        end
        byte_position_next = header_pos_inc;
        if (header_pos_inc == WALK_POS) begin
          next_sec = find_section(section_mask_next, 4'd0);
          if (next_sec == NO_SECTION) begin
            body_active_next = 1'b0;
          end else begin
            current_section_next = next_sec;
            section_byte_next    = '0;
          end
        end
      end else if (current_section >= NO_SECTION) begin
        body_active_next = 1'b0;
      end else begin
        // Pick the quantity base of a section of three 16-bit values.
        kept = 1'b1;
        unique case (current_section)
          SEC_ACCEL: base = Q_ACCEL_X;
          SEC_GYRO:  base = Q_GYRO_X;
          SEC_MAG:   base = Q_MAG_X;
          SEC_EULER: base = Q_ROLL;
          default:   kept = 1'b0;
        endcase

        if (kept) begin
          if (!section_byte[0]) begin
            value_accumulator_next = {16'h0000, data_byte};
          end else begin
            value_accumulator_next = {{8{data_byte[7]}}, data_byte,
                                      value_accumulator[7:0]};
            res.valid     = 1'b1;
            res.quantity  = base + 4'(section_byte[2:1]);
            res.raw_value = {{8{data_byte[7]}}, data_byte, value_accumulator[7:0]};
          end
        end else if (current_section == SEC_BARO) begin
          // Temperature is skipped; pressure and height are 24-bit values.
          unique case (section_byte)
            3'd2, 3'd5: value_accumulator_next = {16'h0000, data_byte};
            3'd3, 3'd6: value_accumulator_next = {8'h00, data_byte,
                                                  value_accumulator[7:0]};
            3'd4, 3'd7: begin
              value_accumulator_next = {data_byte, value_accumulator[15:0]};
              res.valid     = 1'b1;
              res.quantity  = (section_byte == 3'd7) ? Q_HEIGHT : Q_PRESSURE;
              res.raw_value = {data_byte, value_accumulator[15:0]};
            end
            default: ;
          endcase
        end

        // Advance within the section or move to the next present one.
        if (section_byte >= section_last(current_section)) begin
          next_sec = find_section(section_mask, current_section + 4'd1);
          if (next_sec == NO_SECTION) begin
            body_active_next = 1'b0;
          end else begin
            current_section_next = next_sec;
            section_byte_next    = '0;
          end
        end else begin
          section_byte_next = section_byte + 3'd1;
        end
      end
    end
  end

  // Parser state registers, updated only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      body_active       <= 1'b0;
      section_mask      <= '0;
      current_section   <= '0;
      section_byte      <= '0;
      value_accumulator <= '0;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      body_active       <= body_active_next;
      section_mask      <= section_mask_next;
      current_section   <= current_section_next;
      section_byte      <= section_byte_next;
      value_accumulator <= value_accumulator_next;
    end
  end

endmodule

FILE: src/imu_report_field_extractor.sv
// Top level of the IMU report field extractor: stream ports and result register.
// Depends on imu_rfe_pkg and imu_rfe_walk.
//
// Usage: report body bytes enter on the s_ group, one item per byte; s_tuser
// marks the tag byte that opens a body. Bodies with a tag other than 0x11 are
// dropped. Kept quantities (accel, gyro, mag, pressure, height, Euler angles)
// leave on the m_ group: m_tuser carries the quantity code and m_tdata the
// 24-bit value, with 16-bit values sign-extended to 24 bits.
// A result is registered and appears on m_tvalid in the cycle after the byte
// that completes it is accepted. Throughput: one byte per cycle while no result
// waits; the parser updates its state in the same cycle an item is accepted.
// Reset: rst clears the parser (no body active) and empties the result
// register. Stall: while a result waits with m_tready low, s_tready is low
// and no byte is taken; in the cycle m_tready rises, the waiting result
// leaves and the next byte is accepted, so nothing is lost.
module imu_report_field_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] body_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] raw_value
  output logic [3:0]  m_tuser    // [3:0] quantity
);
  import imu_rfe_pkg::*;

  result_t            res;
  logic               accept;
  logic [3:0]         quantity;
  logic signed [23:0] raw_value;

  // Accept while the result register is empty or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  imu_rfe_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .body_start (s_tuser),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      quantity  <= res.quantity;
      raw_value <= res.raw_value;
    end
  end

  assign m_tdata = raw_value;
  assign m_tuser = quantity;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

  a_quantity_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= Q_LAST))
    else $error("quantity code out of range");

  a_sixteen_bit_sext: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != Q_PRESSURE && m_tuser != Q_HEIGHT)
      |-> (m_tdata[23:16] == {8{m_tdata[15]}}))
    else $error("16-bit value not sign-extended");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the IMU report field extractor.
// Depends on imu_rfe_pkg and imu_report_field_extractor; drives report bodies
// with random idling; checks each emitted value against a local predictor or typed row.
module tb;
  import imu_rfe_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int CALM_ITEMS  = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_N       = 25;

  // Byte length of each section, by mask bit.
  localparam int SECT_BYTES [12] = '{6, 6, 6, 6, 8, 8, 6, 6, 5, 6, 2, 1};

  typedef struct packed {
    logic [3:0]  quantity;
    logic [23:0] raw_value;
  } value_t;

  // One directed row; typed rows carry their expected value inline.
  typedef struct packed {
    logic        start;
    logic [7:0]  data;
    logic        typed;
    logic [3:0]  quantity;
    logic [23:0] raw_value;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tuser = 1'b0;   // [0] body_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [23:0] raw_value
  logic [3:0]  m_tuser;          // [3:0] quantity

  // Predictor state.
  logic [2:0]  hdr_pos;
  logic        in_body;
  logic [11:0] present_mask;
  logic [3:0]  walk_sec;
  logic [2:0]  walk_byte;
  logic [23:0] assembled;

  value_t pending_values [$];
  int     error_count = 0;
  int     bytes_sent = 0;
  int     bodies_sent = 0;
  int     values_checked = 0;
  int     cycle_count = 0;
  logic [13:0] quantities_seen = '0;
  bit     calm = 1'b0;
  int     stall_left = 0;
  bit     rx_quiet = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, 8'hFF, 1'b0, 4'd0, 24'd0},                 // byte before any tag
    '{1'b1, REPORT_TAG, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h02, 1'b0, 4'd0, 24'd0},                 // accel section only
    '{1'b0, 8'hF0, 1'b0, 4'd0, 24'd0},                 // high nibble ignored
    '{1'b0, 8'h00, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'hFF, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'hAA, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h55, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h00, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h80, 1'b1, Q_ACCEL_X, 24'hFF8000},       // most negative
    '{1'b0, 8'hFF, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h7F, 1'b1, Q_ACCEL_X + 4'd1, 24'h007FFF}, // most positive
    '{1'b0, 8'h55, 1'b0, 4'd0, 24'd0},                 // partial value
    '{1'b1, 8'h22, 1'b0, 4'd0, 24'd0},                 // abandons, wrong tag
    '{1'b0, REPORT_TAG, 1'b0, 4'd0, 24'd0},            // tag value, not a start
    '{1'b1, REPORT_TAG, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h00, 1'b0, 4'd0, 24'd0},                 // empty mask
    '{1'b0, 8'h00, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h01, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h02, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h03, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h04, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h33, 1'b0, 4'd0, 24'd0},                 // after the body ended
    '{1'b1, 8'hFF, 1'b0, 4'd0, 24'd0},
    '{1'b0, 8'h00, 1'b0, 4'd0, 24'd0}
  };

  imu_report_field_extractor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Move to the next present section at or above 'from', or end the body.
  function automatic void enter_next_section(input int from);
    int s;
    s = from;
    while (s < NUM_SECTIONS && !present_mask[s]) s++;
    if (s >= NUM_SECTIONS) begin
      in_body = 1'b0;
    end else begin
      walk_sec  = 4'(s);
      walk_byte = 3'd0;
    end
  endfunction

  // Advance the parser by one byte; 'hit' is set when a value completes.
  function automatic void extract_from_byte(input logic start, input logic [7:0] b,
                                            output bit hit, output value_t val);
    logic [3:0] base;
    bit         kept16;
    int         k;
    hit = 1'b0;
    val = '0;
    if (start) begin
      in_body      = (b == REPORT_TAG);
      hdr_pos      = 3'd1;
      present_mask = '0;
      walk_sec     = '0;
      walk_byte    = '0;
      assembled    = '0;
      return;
    end
    if (!in_body) return;

    // Header: tag already seen, then mask low, mask high and four skipped bytes.
    if (hdr_pos != WALK_POS) begin
      if (hdr_pos == 3'd1) present_mask[7:0] = b;
      else if (hdr_pos == 3'd2) present_mask[11:8] = b[3:0];
      hdr_pos = hdr_pos + 3'd1;
      if (hdr_pos == WALK_POS) enter_next_section(0);
      return;
    end

    kept16 = 1'b1;
    base   = '0;
    case (walk_sec)
      SEC_ACCEL: base = Q_ACCEL_X;
      SEC_GYRO:  base = Q_GYRO_X;
      SEC_MAG:   base = Q_MAG_X;
      SEC_EULER: base = Q_ROLL;
      default:   kept16 = 1'b0;
    endcase

    if (kept16) begin
      if (!walk_byte[0]) begin
        assembled = {16'd0, b};
      end else begin
        assembled = {{8{b[7]}}, b, assembled[7:0]};
        hit = 1'b1;
        val.quantity = base + 4'(walk_byte[2:1]);
      end
    end else if (walk_sec == SEC_BARO && walk_byte >= 3'd2) begin
      // Temperature word first, then two 24-bit values.
      k = (int'(walk_byte) - 2) % 3;
      if (k == 0) begin
        assembled = {16'd0, b};
      end else if (k == 1) begin
        assembled = {8'd0, b, assembled[7:0]};
      end else begin
        assembled = {b, assembled[15:0]};
        hit = 1'b1;
        val.quantity = (walk_byte >= 3'd5) ? Q_HEIGHT : Q_PRESSURE;
      end
    end
    val.raw_value = assembled;

    if (int'(walk_byte) + 1 >= SECT_BYTES[walk_sec]) enter_next_section(int'(walk_sec) + 1);
    else walk_byte = walk_byte + 3'd1;
  endfunction

  // Offer one item after an optional idle gap and wait for it to be taken.
  task automatic send_item(input logic start, input logic [7:0] b, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    bytes_sent++;
    if (start) bodies_sent++;
  endtask

  // Send a byte and queue whatever the predictor says it produces.
  task automatic send_and_predict(input logic start, input logic [7:0] b, input int gap);
    bit     hit;
    value_t val;
    send_item(start, b, gap);
    extract_from_byte(start, b, hit, val);
    if (hit) pending_values.push_back(val);
  endtask

  function automatic int pick_gap(input bit gappy);
    if (!calm && gappy && $urandom_range(0, 9) == 0) return $urandom_range(1, 18);
    return 0;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver side: random stall bursts, quiet stretches, none at the end.
  always @(negedge clk) begin
    if (rst || calm || rx_quiet) begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 299) == 0) rx_quiet <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 199) == 0) rx_quiet <= 1'b1;
    end
  end

  // Compare each emitted value with the oldest one predicted.
  always @(posedge clk) begin : value_check
    value_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_values.size() == 0) begin
        error_count++;
        $display("%0t: value with none expected: quantity %0d raw_value %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_values.pop_front();
        values_checked++;
        quantities_seen[want.quantity] = 1'b1;
        if (m_tuser !== want.quantity) begin
          error_count++;
          $display("%0t: quantity expected %0d, got %0d", $time, want.quantity, m_tuser);
        end
        if (m_tdata !== want.raw_value) begin
          error_count++;
          $display("%0t: raw_value expected %h, got %h (quantity %0d)",
                   $time, want.raw_value, m_tdata, want.quantity);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d values outstanding", $time, pending_values.size());
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [8:0]  body_q [$];
    logic [15:0] mask;
    bit          gappy;
    bit          drained;
    bit          hit;
    value_t      val;
    int          kind;
    int          cut;
    int          n;

    drained   = 1'b0;
    hdr_pos   = '0;
    in_body   = 1'b0;
    present_mask = '0;
    walk_sec  = '0;
    walk_byte = '0;
    assembled = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part: typed rows carry their own expectation.
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].start, dir_rows[i].data, pick_gap(1'b1));
      extract_from_byte(dir_rows[i].start, dir_rows[i].data, hit, val);
      if (dir_rows[i].typed) begin
        pending_values.push_back({dir_rows[i].quantity, dir_rows[i].raw_value});
      end else if (hit) begin
        pending_values.push_back(val);
      end
    end

    // Random part: mostly well-formed bodies, some broken ones and noise.
    while (bytes_sent < ITEM_TARGET) begin
      body_q.delete();
      kind  = $urandom_range(0, 99);
      gappy = ($urandom_range(0, 2) != 0);
      if (kind < 75) begin
        mask = 16'($urandom_range(0, 16'hFFFF));
        if (kind < 25) mask = mask & 16'($urandom_range(0, 16'hFFFF));
        if (kind == 0) mask = 16'h0000;
        if (kind == 1) mask = 16'hFFFF;
        body_q.push_back({1'b1, REPORT_TAG});
        body_q.push_back({1'b0, mask[7:0]});
        body_q.push_back({1'b0, mask[15:8]});
        repeat (4) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        for (int s = 0; s < NUM_SECTIONS; s++) begin
          if (mask[s]) repeat (SECT_BYTES[s]) body_q.push_back({1'b0, payload_byte()});
        end
        // Some bodies are cut short at a random point; some others get one to four extra bytes.
        if ($urandom_range(0, 99) < 15) begin
          cut = $urandom_range(1, body_q.size() - 1);
          while (body_q.size() > cut) void'(body_q.pop_back());
        end else if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
      end else if (kind < 88) begin
        body_q.push_back({1'b1, 8'($urandom_range(0, 255))});
        n = $urandom_range(0, 12);
        repeat (n) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end

      foreach (body_q[i]) send_and_predict(body_q[i][8], body_q[i][7:0], pick_gap(gappy));

      if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
        // Hold off until every predicted value has come out.
        drained = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(negedge clk);
      end
      if (bytes_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("tb: %0d bytes in %0d bodies, %0d values checked", bytes_sent, bodies_sent,
             values_checked);
    $display("tb: quantity codes seen %b (bit 0 = accel x)", quantities_seen);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
